>>> hw/rtl/fsbu_pkg.sv
// Shared types and constants for the double-precision stack machine.
// Used by fsbu_fpu, float_stack_bytecode_unit, its checker and testbench; depends on nothing else.
`default_nettype none

package fsbu_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int POOL_DEPTH_DEF  = 1024;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 10;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 9;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 80;

    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
    localparam logic [OP_W-1:0] OP_NEG  = 3'd6;
    localparam logic [OP_W-1:0] OP_RET  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNF  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RET  = 2'd3;

    localparam logic [1:0] FOP_ADD = 2'd0;
    localparam logic [1:0] FOP_SUB = 2'd1;
    localparam logic [1:0] FOP_MUL = 2'd2;
    localparam logic [1:0] FOP_DIV = 2'd3;

    localparam logic [WORD_W-1:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [WORD_W-1:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [WORD_W-1:0] INVALID_NAN = 64'hFFF8_0000_0000_0000;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } fpu_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/fsbu_fpu.sv
// Iterative double-precision add, subtract, multiply and divide unit.
// Separate add, multiply-step, divide-step and rounding datapaths run under a small sequencer; uses fsbu_pkg.
`default_nettype none

module fsbu_fpu
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fsbu_pkg::fpu_ctl_t ctl,
    input  wire logic [63:0]      a,
    input  wire logic [63:0]      b,
    output logic                  done,
    output logic [63:0]           result
);
    import fsbu_pkg::*;

    localparam logic [2:0] F_IDLE    = 3'd0;
    localparam logic [2:0] F_CHECK   = 3'd1;
    localparam logic [2:0] F_PRENORM = 3'd2;
    localparam logic [2:0] F_MUL     = 3'd3;
    localparam logic [2:0] F_DIV     = 3'd4;
    localparam logic [2:0] F_NORM    = 3'd5;
    localparam logic [2:0] F_ROUND   = 3'd6;
    localparam logic [2:0] F_DONE    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [63:0]         a_reg, a_next, b_reg, b_next;
    logic                sign_reg, sign_next;
    logic signed [13:0]  exp_reg, exp_next;
    logic [63:0]         man_reg, man_next;
    logic [52:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic signed [13:0]  ea_reg, ea_next, eb_reg, eb_next;
    logic [106:0]        prod_reg, prod_next;
    logic [54:0]         rem_reg, rem_next;
    logic [61:0]         quo_reg, quo_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [63:0]         res_reg, res_next;

    // Operand classification.
    logic        sa, sb, sbe, sx;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [10:0] ea_u, eb_u;
    logic [52:0] ma_u, mb_u;
    logic        special;
    logic [63:0] special_res;

    // Alignment and add.
    logic        swap;
    logic [52:0] mbig, msmall;
    logic [10:0] ebig, esmall, shift_d;
    logic [63:0] big_w, small_w, small_sh, add_man;

    // Rounding.
    logic        rnd_up;
    logic [53:0] r54;
    logic signed [13:0] exp_p1;
    logic [63:0] round_res, inf_res;

    // Multiply and divide steps.
    logic [53:0] mul_sum;
    logic        div_ge;
    logic [54:0] div_r;

    always_comb
    begin
        sa     = a_reg[63];
        sb     = b_reg[63];
        sbe    = b_reg[63] ^ (op_reg == FOP_SUB);
        sx     = sa ^ sb;
        a_nan  = (a_reg[62:52] == 11'h7FF) && (a_reg[51:0] != 52'd0);
        b_nan  = (b_reg[62:52] == 11'h7FF) && (b_reg[51:0] != 52'd0);
        a_inf  = (a_reg[62:52] == 11'h7FF) && (a_reg[51:0] == 52'd0);
        b_inf  = (b_reg[62:52] == 11'h7FF) && (b_reg[51:0] == 52'd0);
        a_zero = (a_reg[62:0] == 63'd0);
        b_zero = (b_reg[62:0] == 63'd0);
        ea_u   = (a_reg[62:52] == 11'd0) ? 11'd1 : a_reg[62:52];
        eb_u   = (b_reg[62:52] == 11'd0) ? 11'd1 : b_reg[62:52];
        ma_u   = {a_reg[62:52] != 11'd0, a_reg[51:0]};
        mb_u   = {b_reg[62:52] != 11'd0, b_reg[51:0]};

        special     = 1'b1;
        special_res = 64'd0;
        if ((op_reg == FOP_DIV) && b_zero)
        begin
            if (a_nan)
                special_res = a_reg | QUIET_BIT;
            else if (a_zero)
                special_res = DEFAULT_NAN;
            else
                special_res = {sx, 11'h7FF, 52'd0};
        end
        else if (a_nan)
            special_res = a_reg | QUIET_BIT;
        else if (b_nan)
            special_res = b_reg | QUIET_BIT;
        else
        begin
            case (op_reg)
                FOP_ADD, FOP_SUB:
                begin
                    if (a_inf && b_inf)
                        special_res = (sa != sbe) ? INVALID_NAN : a_reg;
                    else if (a_inf)
                        special_res = a_reg;
                    else if (b_inf)
                        special_res = {sbe, b_reg[62:0]};
                    else if (a_zero && b_zero)
                        special_res = {sa & sbe, 63'd0};
                    else if (a_zero)
                        special_res = {sbe, b_reg[62:0]};
                    else if (b_zero)
                        special_res = a_reg;
                    else
                        special = 1'b0;
                end
                FOP_MUL:
                begin
                    if ((a_inf && b_zero) || (a_zero && b_inf))
                        special_res = INVALID_NAN;
                    else if (a_inf || b_inf)
                        special_res = {sx, 11'h7FF, 52'd0};
                    else if (a_zero || b_zero)
                        special_res = {sx, 63'd0};
                    else
                        special = 1'b0;
                end
                default:
                begin
                    if (a_inf && b_inf)
                        special_res = INVALID_NAN;
                    else if (a_inf)
                        special_res = {sx, 11'h7FF, 52'd0};
                    else if (b_inf || a_zero)
                        special_res = {sx, 63'd0};
                    else
                        special = 1'b0;
                end
            endcase
        end
    end

    // The operand of larger magnitude goes first, so a difference never goes negative.
    always_comb
    begin
        swap    = b_reg[62:0] > a_reg[62:0];
        mbig    = swap ? mb_u : ma_u;
        msmall  = swap ? ma_u : mb_u;
        ebig    = swap ? eb_u : ea_u;
        esmall  = swap ? ea_u : eb_u;
        shift_d = ebig - esmall;
        big_w   = {1'b0, mbig, 10'd0};
        small_w = {1'b0, msmall, 10'd0};
        if (shift_d >= 11'd64)
            small_sh = {63'd0, |msmall};
        else
            small_sh = (small_w >> shift_d[5:0])
                     | {63'd0, |(small_w & ((64'd1 << shift_d[5:0]) - 64'd1))};
        add_man = (sa == sbe) ? big_w + small_sh : big_w - small_sh;
    end

    always_comb
    begin
        rnd_up  = man_reg[9] & ((|man_reg[8:0]) | man_reg[10]);
        r54     = {1'b0, man_reg[62:10]} + {53'd0, rnd_up};
        exp_p1  = exp_reg + 14'sd1;
        inf_res = {sign_reg, 11'h7FF, 52'd0};
        if (exp_reg >= 14'sd2047)
            round_res = inf_res;
        else if (r54[53])
            round_res = (exp_p1 >= 14'sd2047) ? inf_res : {sign_reg, exp_p1[10:0], 52'd0};
        else
            round_res = {sign_reg, r54[52] ? exp_reg[10:0] : 11'd0, r54[51:0]};
    end

    always_comb
    begin
        mul_sum = prod_reg[106:53] + (prod_reg[0] ? {1'b0, ma_reg} : 54'd0);
        div_ge  = rem_reg >= {2'b0, mb_reg};
        div_r   = div_ge ? rem_reg - {2'b0, mb_reg} : rem_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sign_next  = sign_reg;
        exp_next   = exp_reg;
        man_next   = man_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        done       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (ctl.start)
                begin
                    a_next     = a;
                    b_next     = b;
                    op_next    = ctl.op;
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                if (special)
                begin
                    res_next   = special_res;
                    state_next = F_DONE;
                end
                else if ((op_reg == FOP_ADD) || (op_reg == FOP_SUB))
                begin
                    man_next   = add_man;
                    exp_next   = $signed({3'b000, ebig});
                    sign_next  = (add_man == 64'd0) ? 1'b0 : (swap ? sbe : sa);
                    state_next = F_NORM;
                end
                else
                begin
                    ma_next    = ma_u;
                    mb_next    = mb_u;
                    ea_next    = $signed({3'b000, ea_u});
                    eb_next    = $signed({3'b000, eb_u});
                    sign_next  = sx;
                    state_next = F_PRENORM;
                end
            end
            F_PRENORM:
            begin
                // Subnormal operands are brought to a leading one first.
                if (ma_reg[52] && mb_reg[52])
                begin
                    cnt_next = 6'd0;
                    if (op_reg == FOP_MUL)
                    begin
                        prod_next  = {54'd0, mb_reg};
                        exp_next   = ea_reg + eb_reg - 14'sd1023;
                        state_next = F_MUL;
                    end
                    else
                    begin
                        rem_next   = {2'b00, ma_reg};
                        quo_next   = 62'd0;
                        exp_next   = ea_reg - eb_reg + 14'sd1023;
                        state_next = F_DIV;
                    end
                end
                else
                begin
                    if (!ma_reg[52])
                    begin
                        ma_next = {ma_reg[51:0], 1'b0};
                        ea_next = ea_reg - 14'sd1;
                    end
                    if (!mb_reg[52])
                    begin
                        mb_next = {mb_reg[51:0], 1'b0};
                        eb_next = eb_reg - 14'sd1;
                    end
                end
            end
            F_MUL:
            begin
                if (cnt_reg == 6'd53)
                begin
                    man_next   = {prod_reg[105:43], prod_reg[42] | (|prod_reg[41:0])};
                    state_next = F_NORM;
                end
                else
                begin
                    prod_next = {1'b0, mul_sum, prod_reg[52:1]};
                    cnt_next  = cnt_reg + 6'd1;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == 6'd62)
                begin
                    man_next   = {1'b0, quo_reg, rem_reg != 55'd0};
                    state_next = F_NORM;
                end
                else
                begin
                    rem_next = {div_r[53:0], 1'b0};
                    quo_next = {quo_reg[60:0], div_ge};
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            F_NORM:
            begin
                if (man_reg == 64'd0)
                begin
                    res_next   = {sign_reg, 63'd0};
                    state_next = F_DONE;
                end
                else if (man_reg[63])
                begin
                    man_next = {1'b0, man_reg[63:2], man_reg[1] | man_reg[0]};
                    exp_next = exp_reg + 14'sd1;
                end
                else if (exp_reg < 14'sd1)
                begin
                    // Far below the subnormal range only a sticky bit is left.
                    if (exp_reg < -14'sd64)
                    begin
                        man_next = 64'd1;
                        exp_next = 14'sd1;
                    end
                    else
                    begin
                        man_next = {1'b0, man_reg[63:2], man_reg[1] | man_reg[0]};
                        exp_next = exp_reg + 14'sd1;
                    end
                end
                else if (!man_reg[62] && (exp_reg > 14'sd1))
                begin
                    man_next = {man_reg[62:0], 1'b0};
                    exp_next = exp_reg - 14'sd1;
                end
                else
                    state_next = F_ROUND;
            end
            F_ROUND:
            begin
                res_next   = round_res;
                state_next = F_DONE;
            end
            default:
            begin
                done       = 1'b1;
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sign_reg <= sign_next;
        exp_reg  <= exp_next;
        man_reg  <= man_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/float_stack_bytecode_unit.sv
// Top level of the double-precision stack machine: value stack, constant pool,
// instruction sequencer and output register. Uses fsbu_pkg and fsbu_fpu.
`default_nettype none

// Channel   Direction  Contents
// s_*       in         one decoded instruction word per handshake
// m_*       out        one result word per instruction
//
// Load, negate, rejected instructions and a return that empties the stack go from the
// accept straight to the result word; push constant and any other return pass through a
// read state first. Add, subtract, multiply and divide then wait on the shared iterative
// unit: one product or quotient bit per cycle, one bit of operand prenormalization and
// one bit of result normalization per cycle.
// Reset clears the state and the stack count only; no clearing pass.
// A result word waits in the output register until taken; no new word is
// accepted meanwhile.
module float_stack_bytecode_unit
#(
    parameter int STACK_DEPTH = fsbu_pkg::STACK_DEPTH_DEF,
    parameter int POOL_DEPTH  = fsbu_pkg::POOL_DEPTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // operation[2:0], pool_index[12:3], pool_value[76:13], zero fill
    input  wire logic [fsbu_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // status[1:0], result_value[65:2], depth[74:66], zero fill
    output logic [fsbu_pkg::OUT_W-1:0]     m_tdata
);
    import fsbu_pkg::*;

    localparam int SA  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int PA  = $clog2(POOL_DEPTH);
    localparam int IW  = ((PA > INDEX_W) ? PA : INDEX_W) + 1;
    localparam int MOD_STEPS = ((2 ** INDEX_W) - 1) / POOL_DEPTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FPU  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]   value_reg, value_next;

    logic [WORD_W-1:0]   stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0]   pool_mem  [POOL_DEPTH];
    logic [WORD_W-1:0]   stk_rd_reg, pool_rd_reg;

    logic                stk_we, stk_re, pool_we, pool_re;
    logic [SA-1:0]       stk_waddr, stk_raddr;
    logic [WORD_W-1:0]   stk_wdata;
    logic [PA-1:0]       pool_addr;

    logic [OP_W-1:0]     in_op;
    logic [INDEX_W-1:0]  in_index;
    logic [WORD_W-1:0]   in_value;
    logic                accept;
    logic [IW-1:0]       index_mod;
    logic [CW-1:0]       cnt_m1, cnt_m2;
    logic [WORD_W-1:0]   top_or_zero;
    logic [DEPTH_W+CW-1:0] depth_ext;

    fpu_ctl_t            fpu_ctl;
    logic                fpu_done;
    logic [WORD_W-1:0]   fpu_result;

    assign in_op    = s_tdata[2:0];
    assign in_index = s_tdata[12:3];
    assign in_value = s_tdata[76:13];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);

    assign cnt_m1      = cnt_reg - CW'(1);
    assign cnt_m2      = cnt_reg - CW'(2);
    assign top_or_zero = (cnt_reg == '0) ? '0 : top_reg;
    assign depth_ext   = {{DEPTH_W{1'b0}}, cnt_reg};
    assign m_tdata     = {{(OUT_W - DEPTH_W - WORD_W - STATUS_W){1'b0}},
                          depth_ext[DEPTH_W-1:0], value_reg, status_reg};

    // Pool indexes wrap at the pool size; at most MOD_STEPS subtractions are needed.
    always_comb
    begin
        index_mod = IW'(in_index);
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (index_mod >= IW'(POOL_DEPTH))
                index_mod = index_mod - IW'(POOL_DEPTH);
        end
        pool_addr = index_mod[PA-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        top_next    = top_reg;
        status_next = status_reg;
        value_next  = value_reg;
        stk_we      = 1'b0;
        stk_re      = 1'b0;
        pool_we     = 1'b0;
        pool_re     = 1'b0;
        stk_waddr   = cnt_m1[SA-1:0];
        stk_wdata   = top_reg;
        stk_raddr   = cnt_m2[SA-1:0];
        fpu_ctl     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    status_next = ST_OK;
                    value_next  = top_or_zero;
                    state_next  = S_OUT;
                    case (in_op)
                        OP_LOAD:
                            pool_we = 1'b1;
                        OP_PUSH:
                        begin
                            if (cnt_reg == CW'(STACK_DEPTH))
                                status_next = ST_OVF;
                            else
                            begin
                                pool_re    = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            if (cnt_reg < CW'(2))
                                status_next = ST_UNF;
                            else
                            begin
                                stk_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_NEG:
                        begin
                            if (cnt_reg == '0)
                                status_next = ST_UNF;
                            else
                            begin
                                top_next   = top_reg ^ SIGN_BIT;
                                stk_we     = 1'b1;
                                stk_wdata  = top_reg ^ SIGN_BIT;
                                value_next = top_reg ^ SIGN_BIT;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                                status_next = ST_UNF;
                            else
                            begin
                                status_next = ST_RET;
                                value_next  = top_reg;
                                cnt_next    = cnt_m1;
                                // The entry below becomes the cached top.
                                if (cnt_reg >= CW'(2))
                                begin
                                    stk_re     = 1'b1;
                                    state_next = S_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                case (op_reg)
                    OP_PUSH:
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = cnt_reg[SA-1:0];
                        stk_wdata  = pool_rd_reg;
                        top_next   = pool_rd_reg;
                        value_next = pool_rd_reg;
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_OUT;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        fpu_ctl.start = 1'b1;
                        case (op_reg)
                            OP_ADD:  fpu_ctl.op = FOP_ADD;
                            OP_SUB:  fpu_ctl.op = FOP_SUB;
                            OP_MUL:  fpu_ctl.op = FOP_MUL;
                            default: fpu_ctl.op = FOP_DIV;
                        endcase
                        state_next = S_FPU;
                    end
                    default:
                    begin
                        top_next   = stk_rd_reg;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_FPU:
            begin
                if (fpu_done)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = cnt_m2[SA-1:0];
                    stk_wdata  = fpu_result;
                    top_next   = fpu_result;
                    value_next = fpu_result;
                    cnt_next   = cnt_m1;
                    state_next = S_OUT;
                end
            end
            default:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        top_reg    <= top_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rd_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
            pool_mem[pool_addr] <= in_value;
        if (pool_re)
            pool_rd_reg <= pool_mem[pool_addr];
    end

    fsbu_fpu u_fpu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (fpu_ctl),
        .a      (stk_rd_reg),
        .b      (top_reg),
        .done   (fpu_done),
        .result (fpu_result)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond stack size");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CW'(1))
        || (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("stack count moved by more than one entry");

    a_fpu_start: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_ctl.start |-> (state_reg == S_READ) && (cnt_reg >= CW'(2)))
        else $error("arithmetic started without two operands");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_done |-> (state_reg == S_FPU))
        else $error("arithmetic result arrived outside its wait state");

    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_LOAD)) |=> m_tvalid && (status_reg == ST_OK))
        else $error("pool load did not report at once");

endmodule

`default_nettype wire

>>> dv/float_stack_bytecode_unit_checker.sv
// Checker for the double-precision stack machine: watches both stream channels,
// keeps its own copy of the stack and constant pool, and compares every result word.
// Depends on fsbu_pkg for field widths, operation and status codes.
module float_stack_bytecode_unit_checker
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [fsbu_pkg::IN_W-1:0] s_tdata,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [fsbu_pkg::OUT_W-1:0] m_tdata,
    output int                             errors,
    output int                             pending
);
    import fsbu_pkg::*;

    localparam int STK_N  = STACK_DEPTH_DEF;
    localparam int POOL_N = POOL_DEPTH_DEF;
    localparam logic [WORD_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [WORD_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   value;
        logic [DEPTH_W-1:0]  depth;
    } outcome_t;

    logic [WORD_W-1:0] stack_mem [STK_N];
    logic [WORD_W-1:0] pool_mem  [POOL_N];
    int                stack_cnt;
    outcome_t          outcome_q[$];

    function automatic logic [WORD_W-1:0] fp_divide(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        if ((b & ~SIGN_BIT) == '0)
        begin
            if ((a & EXP_MASK) == EXP_MASK && (a & FRAC_MASK) != '0)
                return a | QUIET_BIT;
            if ((a & ~SIGN_BIT) == '0)
                return DEFAULT_NAN;
            return ((a ^ b) & SIGN_BIT) | EXP_MASK;
        end
        return $realtobits($bitstoreal(a) / $bitstoreal(b));
    endfunction

    // Applies one instruction to the shadow state and returns the word it should produce.
    function automatic outcome_t execute(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                         logic [WORD_W-1:0] val);
        outcome_t          res;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] r;
        bit                popped;
        res = '0;
        popped = 0;
        case (op)
            OP_LOAD: pool_mem[idx] = val;
            OP_PUSH:
                if (stack_cnt >= STK_N)
                    res.status = ST_OVF;
                else
                begin
                    stack_mem[stack_cnt] = pool_mem[idx];
                    stack_cnt++;
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                if (stack_cnt < 2)
                    res.status = ST_UNF;
                else
                begin
                    b = stack_mem[stack_cnt-1];
                    a = stack_mem[stack_cnt-2];
                    case (op)
                        OP_ADD:  r = $realtobits($bitstoreal(a) + $bitstoreal(b));
                        OP_SUB:  r = $realtobits($bitstoreal(a) - $bitstoreal(b));
                        OP_MUL:  r = $realtobits($bitstoreal(a) * $bitstoreal(b));
                        default: r = fp_divide(a, b);
                    endcase
                    stack_cnt--;
                    stack_mem[stack_cnt-1] = r;
                end
            OP_NEG:
                if (stack_cnt < 1)
                    res.status = ST_UNF;
                else
                    stack_mem[stack_cnt-1] ^= SIGN_BIT;
            default:
                if (stack_cnt < 1)
                    res.status = ST_UNF;
                else
                begin
                    stack_cnt--;
                    res.value = stack_mem[stack_cnt];
                    res.status = ST_RET;
                    popped = 1;
                end
        endcase
        if (!popped)
            res.value = (stack_cnt == 0) ? '0 : stack_mem[stack_cnt-1];
        res.depth = stack_cnt[DEPTH_W-1:0];
        return res;
    endfunction

    task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            stack_cnt = 0;
            outcome_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(execute(s_tdata[OP_W-1:0], s_tdata[OP_W+INDEX_W-1:OP_W],
                                            s_tdata[OP_W+INDEX_W+WORD_W-1:OP_W+INDEX_W]));
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[1:0];
                got.value  = m_tdata[65:2];
                got.depth  = m_tdata[74:66];
                if (outcome_q.size() == 0)
                    report("unexpected result word, status", WORD_W'(got.status), '0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status)
                        report("status", WORD_W'(got.status), WORD_W'(want.status));
                    if (got.value != want.value)
                        report("result_value", got.value, want.value);
                    if (got.depth != want.depth)
                        report("depth", WORD_W'(got.depth), WORD_W'(want.depth));
                end
            end
            pending = outcome_q.size();
        end
    end

    final_check: assert property (@(posedge clk) 1);
endmodule

>>> dv/tb_float_stack_bytecode_unit.sv
// Testbench top for float_stack_bytecode_unit: drives instruction words with random
// gaps and back-pressure, and gives the verdict from the checker's failure count or a watchdog.
// Depends on fsbu_pkg, the block itself and float_stack_bytecode_unit_checker.
module tb_float_stack_bytecode_unit;
    import fsbu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    int                 errors;
    int                 pending;
    bit                 hold_request;
    int                 idle_cycles;

    int                 shadow_depth;
    int                 loaded_idx[$];
    bit                 loaded_map[POOL_DEPTH_DEF];

    float_stack_bytecode_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    float_stack_bytecode_unit_checker checker_inst
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Sends one instruction word and then leaves a random gap; the caller is just past an edge.
    task automatic issue(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
        int roll;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, val, idx, op};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        case (op)
            OP_LOAD:
                if (!loaded_map[idx])
                begin
                    loaded_map[idx] = 1;
                    loaded_idx.push_back(int'(idx));
                end
            OP_PUSH: if (shadow_depth < STACK_DEPTH_DEF) shadow_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (shadow_depth >= 2) shadow_depth--;
            OP_RET: if (shadow_depth >= 1) shadow_depth--;
            default: ;
        endcase
        roll = $urandom_range(0, 99);
        gap = (roll < 65) ? 0 : (roll < 95) ? $urandom_range(1, 4) : $urandom_range(20, 120);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return {$urandom, $urandom};
        if (roll < 75)
            return $realtobits(real'($urandom_range(0, 2000)) / 8.0 - 100.0);
        if (roll < 85)
            return $realtobits(real'($urandom) * 1.0e290);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return SIGN_BIT;
            2: return 64'h7FF0_0000_0000_0000;
            3: return 64'hFFF0_0000_0000_0000;
            4: return DEFAULT_NAN;
            default: return {12'h000, 4'($urandom_range(0, 15)), 48'h1};
        endcase
    endfunction

    // Directed part: underflow of every kind, division by zero cases, overflow.
    task automatic directed_run();
        issue(OP_RET, '0, '0);
        issue(OP_NEG, '0, '0);
        issue(OP_ADD, '0, '0);
        issue(OP_LOAD, 10'd0, 64'h3FF0_0000_0000_0000);
        issue(OP_LOAD, 10'd1023, '1);
        issue(OP_LOAD, 10'd5, '0);
        issue(OP_LOAD, 10'd6, SIGN_BIT);
        issue(OP_LOAD, 10'd8, 64'h4004_0000_0000_0000);
        issue(OP_PUSH, 10'd0, '0);
        issue(OP_DIV, '0, '0);
        issue(OP_PUSH, 10'd8, '0);
        issue(OP_ADD, '0, '0);
        issue(OP_PUSH, 10'd8, '0);
        issue(OP_SUB, '0, '0);
        issue(OP_PUSH, 10'd8, '0);
        issue(OP_MUL, '0, '0);
        issue(OP_PUSH, 10'd6, '0);
        issue(OP_DIV, '0, '0);
        issue(OP_PUSH, 10'd5, '0);
        issue(OP_PUSH, 10'd6, '0);
        issue(OP_DIV, '0, '0);
        issue(OP_PUSH, 10'd1023, '0);
        issue(OP_PUSH, 10'd5, '0);
        issue(OP_DIV, '0, '0);
        issue(OP_NEG, '0, '0);
        issue(OP_RET, '0, '0);
        while (shadow_depth > 0)
            issue(OP_RET, '0, '0);
        // Push two more than the stack holds, then drain it again.
        repeat (STACK_DEPTH_DEF + 2)
            issue(OP_PUSH, 10'd0, '0);
        while (shadow_depth > 0)
            issue(OP_RET, '0, '0);
    endtask

    task automatic random_run(int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            if (i == 300)
                hold_request = 1;
            if (i == 700)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 15 || loaded_idx.size() == 0)
                issue(OP_LOAD, INDEX_W'($urandom_range(0, POOL_DEPTH_DEF - 1)), pick_value());
            else if (roll < 45 && shadow_depth < 12)
                issue(OP_PUSH, INDEX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]),
                      '0);
            else if (roll < 80)
                issue(OP_W'(OP_ADD + $urandom_range(0, 3)), INDEX_W'($urandom),
                      {$urandom, $urandom});
            else if (roll < 88)
                issue(OP_NEG, INDEX_W'($urandom), {$urandom, $urandom});
            else
                issue(OP_RET, INDEX_W'($urandom), {$urandom, $urandom});
        end
    endtask

    // Result side: mostly ready, with random short and long stalls and one long hold-off on request.
    initial
    begin
        int roll;
        bit held;
        held = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                held = 1;
                m_tready <= 1'b0;
                repeat (500) @(posedge clk);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    m_tready <= 1'b1;
                else if (roll < 97)
                    m_tready <= 1'b0;
                else
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(20, 150)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL float_stack_bytecode_unit");
        $finish;
    end

    initial
    begin
        hold_request = 0;
        shadow_depth = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_run();
        random_run(760);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS float_stack_bytecode_unit");
        else
            $display("FAIL float_stack_bytecode_unit");
        $finish;
    end
endmodule
